// ===== hdl/sfop_pkg.sv =====
// ----------------------------------------------------------------------------
// sfop_pkg
// Shared types and constants of the spectral flux onset picker.
// ----------------------------------------------------------------------------
package sfop_pkg;

  localparam int FLUX_BITS     = 24;
  localparam int TIME_BITS     = 32;
  localparam int THR_BITS      = 27;
  localparam int STRENGTH_BITS = 8;
  localparam int RATE_BITS     = 17;

  localparam int GAIN_BITS     = 5;
  localparam int FLOOR_BITS    = 16;
  localparam int FRAC_BITS     = 5;
  localparam int DEAF_BITS     = 16;

  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 16;

  localparam int RATE_DEPTH_DEF = 8;
  localparam int RATE_SCALE     = 10000;

  localparam int GAIN_SHIFT = 3;
  localparam int FRAC_SHIFT = 4;
  localparam int MEAN_SHIFT = 7;
  localparam int PEAK_SHIFT = 8;
  localparam int MEAN_ROUND = 2 ** MEAN_SHIFT - 1;

  localparam logic [GAIN_BITS-1:0]  GAIN_RST  = GAIN_BITS'(13);
  localparam logic [FLOOR_BITS-1:0] FLOOR_RST = FLOOR_BITS'(800);
  localparam logic [FRAC_BITS-1:0]  FRAC_RST  = FRAC_BITS'(10);
  localparam logic [DEAF_BITS-1:0]  DEAF_RST  = DEAF_BITS'(130);

  localparam logic [STRENGTH_BITS-1:0] STRENGTH_MAX = '1;
  localparam int                       RATE_MAX     = 2 ** RATE_BITS - 1;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_MEAN_GAIN     = 2'd0,
    REG_SILENCE_FLOOR = 2'd1,
    REG_PEAK_FRACTION = 2'd2,
    REG_DEAF_TIME     = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic                 restart;
    logic [FLUX_BITS-1:0] hop_flux;
    logic [TIME_BITS-1:0] hop_time_ms;
  } in_item_t;

  typedef struct packed {
    logic                     onset;
    logic [STRENGTH_BITS-1:0] strength;
    logic [TIME_BITS-1:0]     judged_time_ms;
    logic [THR_BITS-1:0]      next_threshold;
    logic [RATE_BITS-1:0]     rate_tenths;
  } out_item_t;

  typedef struct packed {
    logic                 en;
    logic [TIME_BITS-1:0] data;
  } ring_wr_t;

  typedef struct packed {
    logic                 full;
    logic [TIME_BITS-1:0] oldest;
  } ring_stat_t;

endpackage

// ===== hdl/sfop_cmpsub.sv =====
// ----------------------------------------------------------------------------
// sfop_cmpsub
// Compare and subtract unit, one quotient bit of the shared divider.
// ----------------------------------------------------------------------------
module sfop_cmpsub #(
  parameter int W = 33
) (
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  output logic         ge,
  output logic [W-1:0] diff
);

  assign ge   = (a >= b);
  assign diff = a - b;

endmodule

// ===== hdl/sfop_ring.sv =====
// ----------------------------------------------------------------------------
// sfop_ring
// Ring of recent onset times, gives the oldest entry once full.
// ----------------------------------------------------------------------------
module sfop_ring import sfop_pkg::*; #(
  parameter int DEPTH = RATE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  ring_wr_t   wr,
  output ring_stat_t stat
);

  localparam int IDX_W = $clog2(DEPTH);

  logic [TIME_BITS-1:0] ring_r [DEPTH];
  logic [IDX_W-1:0]     idx_r, idx_nxt;
  logic                 full_r, full_nxt;

  always_comb begin
    idx_nxt  = idx_r;
    full_nxt = full_r;
    if (wr.en) begin
      if (idx_r == IDX_W'(DEPTH - 1)) begin
        idx_nxt  = '0;
        full_nxt = 1'b1;
      end else begin
        idx_nxt = idx_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r  <= '0;
      full_r <= 1'b0;
    end else begin
      idx_r  <= idx_nxt;
      full_r <= full_nxt;
    end
  end

  // entries hold no reset, they are read only once the ring is full
  always_ff @(posedge clk) begin
    if (wr.en) begin
      ring_r[idx_r] <= wr.data;
    end
  end

  assign stat.full   = full_r;
  assign stat.oldest = ring_r[idx_r];

endmodule

// ===== hdl/spectral_flux_onset_picker.sv =====
// ----------------------------------------------------------------------------
// spectral_flux_onset_picker
// Onset picker for one band group: judges the previous hop against an
// adaptive threshold and reports strength, threshold and onset rate.
// ----------------------------------------------------------------------------
// Each input beat is one hop; the block answers with exactly one result beat
// that judges the hop before it (a restart beat only clears the flux history
// and the last onset time). Items are handled one at a time: in_stall is high
// from acceptance until the result has been loaded into the output register.
// A hop passes through the threshold, judge, update, rethreshold and rate
// states; an onset that needs its strength divided out adds a divider pass
// for its eight quotient bits and a rate on a full onset ring adds one for
// NUM_W bits, NUM_W being the bit width of (RATE_DEPTH-1)*10000 (17 at
// RATE_DEPTH 8); a restart beat goes from the judge state to the done state.
// Both divisions share the single compare-subtract unit, which retires one
// quotient bit per cycle. A finished result waits in the sequencer for as
// long as the output register still holds an unaccepted beat. The next hop
// may be accepted while a result still waits on out_stall.
module spectral_flux_onset_picker import sfop_pkg::*; #(
  parameter int RATE_DEPTH = RATE_DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  in_item_t                 in_data,
  output logic                     out_valid,
  input  logic                     out_stall,
  output out_item_t                out_data,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_idx,
  input  logic [CFG_DATA_BITS-1:0] cfg_wdata
);

  localparam int RATE_NUM = (RATE_DEPTH - 1) * RATE_SCALE;
  localparam int NUM_W    = $clog2(RATE_NUM + 1);
  localparam int QW       = (NUM_W > STRENGTH_BITS) ? NUM_W : STRENGTH_BITS;
  localparam int CNT_W    = $clog2(QW + 1);
  localparam int REM_W    = TIME_BITS + 1;
  localparam int PROD_W   = FLUX_BITS + GAIN_BITS;

  typedef enum logic [2:0] {
    ST_IDLE, ST_THR, ST_JUDGE, ST_DIV, ST_UPDATE, ST_RETHR, ST_RATE, ST_DONE
  } state_t;

  state_t state_r;

  logic [GAIN_BITS-1:0]  gain_r;
  logic [FLOOR_BITS-1:0] floor_r;
  logic [FRAC_BITS-1:0]  frac_r;
  logic [DEAF_BITS-1:0]  deaf_r;

  logic [FLUX_BITS-1:0] last_flux_r, older_flux_r, mean_r, peak_r;
  logic [TIME_BITS-1:0] last_onset_r, prev_hop_r;
  logic [1:0]           hops_r;

  in_item_t                 item_r;
  logic [THR_BITS-1:0]      thr_r;
  logic                     onset_r;
  logic [STRENGTH_BITS-1:0] strength_r;
  logic [TIME_BITS-1:0]     jtime_r;
  logic [RATE_BITS-1:0]     rate_r;

  logic [REM_W-1:0]     rem_r;
  logic [TIME_BITS-1:0] div_r;
  logic [QW-1:0]        dsh_r, quo_r;
  logic [CNT_W-1:0]     cnt_r;
  logic                 div_rate_r;

  logic      out_valid_r;
  out_item_t out_data_r;

  // threshold from the current state
  logic [PROD_W-1:0]   mean_prod, peak_prod;
  logic [THR_BITS-1:0] thr_mean, thr_peak, thr_calc;

  assign mean_prod = PROD_W'(mean_r) * PROD_W'(gain_r);
  assign peak_prod = PROD_W'(peak_r) * PROD_W'(frac_r);
  assign thr_mean  = THR_BITS'(mean_prod >> GAIN_SHIFT) + THR_BITS'(floor_r);
  assign thr_peak  = THR_BITS'(peak_prod >> FRAC_SHIFT);
  assign thr_calc  = (thr_mean > thr_peak) ? thr_mean : thr_peak;

  // judging the previous hop
  logic [TIME_BITS-1:0] since_onset;
  logic [FLUX_BITS-1:0] pk;
  logic                 onset_hit, str_sat;

  assign since_onset = prev_hop_r - last_onset_r;
  assign onset_hit   = (hops_r == 2'd2) && (last_flux_r > older_flux_r) &&
                       (last_flux_r >= item_r.hop_flux) &&
                       (THR_BITS'(last_flux_r) > thr_r) &&
                       (since_onset >= TIME_BITS'(deaf_r));
  assign pk          = (peak_r == '0) ? FLUX_BITS'(1) : peak_r;
  // flux*128/peak reaches 256 exactly when flux >= 2*peak
  assign str_sat     = {1'b0, last_flux_r} >= {pk, 1'b0};

  // peak and mean tracking
  logic [FLUX_BITS-1:0] peak_dec, peak_upd, mean_up, mean_upd;
  logic [FLUX_BITS:0]   mean_dn;

  assign peak_dec = peak_r - (peak_r >> PEAK_SHIFT);
  assign peak_upd = (last_flux_r > peak_dec) ? last_flux_r : peak_dec;
  assign mean_up  = mean_r + ((item_r.hop_flux - mean_r) >> MEAN_SHIFT);
  // downward step rounds toward minus infinity
  assign mean_dn  = ({1'b0, mean_r} - {1'b0, item_r.hop_flux} +
                     (FLUX_BITS + 1)'(MEAN_ROUND)) >> MEAN_SHIFT;
  assign mean_upd = (item_r.hop_flux >= mean_r) ? mean_up :
                    mean_r - mean_dn[FLUX_BITS-1:0];

  // onset ring
  ring_wr_t   ring_wr;
  ring_stat_t ring_stat;

  assign ring_wr.en   = (state_r == ST_JUDGE) && !item_r.restart && onset_hit;
  assign ring_wr.data = prev_hop_r;

  sfop_ring #(
    .DEPTH (RATE_DEPTH)
  ) u_ring (
    .clk   (clk),
    .rst_n (rst_n),
    .wr    (ring_wr),
    .stat  (ring_stat)
  );

  logic [TIME_BITS-1:0] rate_diff;
  logic                 rate_go;

  assign rate_diff = item_r.hop_time_ms - ring_stat.oldest;
  assign rate_go   = ring_stat.full && (item_r.hop_time_ms > ring_stat.oldest);

  // shared divider step
  logic [REM_W-1:0] div_trial, div_diff;
  logic             div_ge;
  logic [QW-1:0]    q_fin;

  assign div_trial = {rem_r[TIME_BITS-1:0], dsh_r[QW-1]};
  assign q_fin     = {quo_r[QW-2:0], div_ge};

  sfop_cmpsub #(
    .W (REM_W)
  ) u_cmpsub (
    .a    (div_trial),
    .b    ({1'b0, div_r}),
    .ge   (div_ge),
    .diff (div_diff)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_valid_r  <= 1'b0;
      gain_r       <= GAIN_RST;
      floor_r      <= FLOOR_RST;
      frac_r       <= FRAC_RST;
      deaf_r       <= DEAF_RST;
      last_flux_r  <= '0;
      older_flux_r <= '0;
      mean_r       <= '0;
      peak_r       <= '0;
      last_onset_r <= '0;
      prev_hop_r   <= '0;
      hops_r       <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          REG_MEAN_GAIN:     gain_r  <= cfg_wdata[GAIN_BITS-1:0];
          REG_SILENCE_FLOOR: floor_r <= cfg_wdata[FLOOR_BITS-1:0];
          REG_PEAK_FRACTION: frac_r  <= cfg_wdata[FRAC_BITS-1:0];
          REG_DEAF_TIME:     deaf_r  <= cfg_wdata[DEAF_BITS-1:0];
          default: ;
        endcase
      end

      // in ST_DONE the output register is reloaded instead
      if (out_valid_r && !out_stall && state_r != ST_DONE) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            item_r  <= in_data;
            state_r <= ST_THR;
          end
        end

        ST_THR: begin
          thr_r   <= thr_calc;
          state_r <= ST_JUDGE;
        end

        ST_JUDGE: begin
          if (item_r.restart) begin
            last_flux_r  <= '0;
            older_flux_r <= '0;
            last_onset_r <= '0;
            onset_r      <= 1'b0;
            strength_r   <= '0;
            jtime_r      <= '0;
            rate_r       <= '0;
            state_r      <= ST_DONE;
          end else begin
            onset_r <= onset_hit;
            jtime_r <= prev_hop_r;
            if (onset_hit) begin
              last_onset_r <= prev_hop_r;
              if (str_sat) begin
                strength_r <= STRENGTH_MAX;
                state_r    <= ST_UPDATE;
              end else begin
                // low bits of flux*128 feed the divider after flux>>1
                rem_r      <= REM_W'(last_flux_r >> 1);
                div_r      <= TIME_BITS'(pk);
                dsh_r      <= {last_flux_r[0], (QW - 1)'(0)};
                quo_r      <= '0;
                cnt_r      <= CNT_W'(STRENGTH_BITS);
                div_rate_r <= 1'b0;
                state_r    <= ST_DIV;
              end
            end else begin
              strength_r <= '0;
              state_r    <= ST_UPDATE;
            end
          end
        end

        ST_DIV: begin
          rem_r <= div_ge ? div_diff : div_trial;
          quo_r <= q_fin;
          dsh_r <= dsh_r << 1;
          cnt_r <= cnt_r - 1'b1;
          if (cnt_r == CNT_W'(1)) begin
            if (div_rate_r) begin
              rate_r  <= (32'(q_fin) > 32'(RATE_MAX)) ? RATE_BITS'(RATE_MAX) :
                         RATE_BITS'(q_fin);
              state_r <= ST_DONE;
            end else begin
              strength_r <= STRENGTH_BITS'(q_fin);
              state_r    <= ST_UPDATE;
            end
          end
        end

        ST_UPDATE: begin
          peak_r       <= peak_upd;
          older_flux_r <= last_flux_r;
          last_flux_r  <= item_r.hop_flux;
          mean_r       <= mean_upd;
          prev_hop_r   <= item_r.hop_time_ms;
          if (hops_r != 2'd2) begin
            hops_r <= hops_r + 2'd1;
          end
          state_r <= ST_RETHR;
        end

        ST_RETHR: begin
          thr_r   <= thr_calc;
          state_r <= ST_RATE;
        end

        ST_RATE: begin
          if (rate_go) begin
            rem_r      <= '0;
            div_r      <= rate_diff;
            dsh_r      <= QW'(RATE_NUM) << (QW - NUM_W);
            quo_r      <= '0;
            cnt_r      <= CNT_W'(NUM_W);
            div_rate_r <= 1'b1;
            state_r    <= ST_DIV;
          end else begin
            rate_r  <= '0;
            state_r <= ST_DONE;
          end
        end

        ST_DONE: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r                <= 1'b1;
            out_data_r.onset           <= onset_r;
            out_data_r.strength        <= strength_r;
            out_data_r.judged_time_ms  <= jtime_r;
            out_data_r.next_threshold  <= thr_r;
            out_data_r.rate_tenths     <= rate_r;
            state_r                    <= ST_IDLE;
          end
        end

        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> state_r == ST_THR)
    else $error("accepted beat did not start the sequencer");

  a_strength_needs_onset: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.onset |-> out_data.strength == '0)
    else $error("strength reported without an onset");

  a_rate_needs_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.rate_tenths != '0 |-> ring_stat.full)
    else $error("rate reported before the onset ring filled");

  a_div_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DIV |-> rem_r[REM_W-1] == 1'b0 && rem_r[TIME_BITS-1:0] < div_r)
    else $error("divider remainder out of range");

endmodule

// ===== bench/onset_result_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// onset_result_checker
// Watches the hop and result channels of the onset picker, tracks register
// writes, predicts every result beat and compares it field by field.
// ----------------------------------------------------------------------------
module onset_result_checker import sfop_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  input  logic                     in_stall,
  input  in_item_t                 in_data,
  input  logic                     out_valid,
  input  logic                     out_stall,
  input  out_item_t                out_data,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_idx,
  input  logic [CFG_DATA_BITS-1:0] cfg_wdata,
  output int                       mismatch_count,
  output int                       pending_count
);

  localparam int RING_DEPTH = RATE_DEPTH_DEF;
  localparam int PTR_BITS   = $clog2(RING_DEPTH);
  localparam longint unsigned THR_MAX = (64'd1 << THR_BITS) - 1;

  // register copies
  logic [GAIN_BITS-1:0]  gain;
  logic [FLOOR_BITS-1:0] floor_lvl;
  logic [FRAC_BITS-1:0]  frac;
  logic [DEAF_BITS-1:0]  deaf_ms;

  // picker state
  logic [FLUX_BITS-1:0] prev_flux;
  logic [FLUX_BITS-1:0] prev2_flux;
  logic [FLUX_BITS-1:0] avg_flux;
  logic [FLUX_BITS-1:0] top_flux;
  logic [TIME_BITS-1:0] fired_ms;
  logic [TIME_BITS-1:0] prev_ms;
  logic [1:0]           hop_count;
  logic [TIME_BITS-1:0] onset_ring [RING_DEPTH];
  logic [PTR_BITS-1:0]  ring_ptr;
  logic                 ring_wrapped;

  out_item_t awaited_results [$];
  int        bad_results = 0;

  function automatic longint unsigned threshold();
    longint unsigned by_mean, by_peak;
    by_mean = ((64'(avg_flux) * gain) >> GAIN_SHIFT) + floor_lvl;
    by_peak = (64'(top_flux) * frac) >> FRAC_SHIFT;
    return (by_mean > by_peak) ? by_mean : by_peak;
  endfunction

  function automatic logic [THR_BITS-1:0] clip_thr(longint unsigned v);
    return (v > THR_MAX) ? THR_BITS'(THR_MAX) : v[THR_BITS-1:0];
  endfunction

  function automatic logic [RATE_BITS-1:0] onset_rate(logic [TIME_BITS-1:0] now);
    longint unsigned span, r;
    if (!ring_wrapped || now <= onset_ring[ring_ptr]) return '0;
    span = now - onset_ring[ring_ptr];
    r = 64'((RING_DEPTH - 1) * RATE_SCALE) / span;
    return (r > RATE_MAX) ? RATE_BITS'(RATE_MAX) : r[RATE_BITS-1:0];
  endfunction

  task automatic clear_state();
    gain         = GAIN_RST;
    floor_lvl    = FLOOR_RST;
    frac         = FRAC_RST;
    deaf_ms      = DEAF_RST;
    prev_flux    = '0;
    prev2_flux   = '0;
    avg_flux     = '0;
    top_flux     = '0;
    fired_ms     = '0;
    prev_ms      = '0;
    hop_count    = '0;
    ring_ptr     = '0;
    ring_wrapped = 1'b0;
    foreach (onset_ring[i]) onset_ring[i] = '0;
  endtask

  // judges the previous hop and updates the picker state
  task automatic judge_hop(input in_item_t hop, output out_item_t res);
    logic [FLUX_BITS-1:0] flux;
    logic [TIME_BITS-1:0] now;
    logic [TIME_BITS-1:0] since_onset;
    longint unsigned      bar_now, ratio;
    res  = '0;
    flux = hop.hop_flux;
    now  = hop.hop_time_ms;
    if (hop.restart) begin
      prev_flux  = '0;
      prev2_flux = '0;
      fired_ms   = '0;
      res.next_threshold = clip_thr(threshold());
    end else begin
      bar_now     = threshold();
      since_onset = prev_ms - fired_ms;
      if (hop_count >= 2 && prev_flux > prev2_flux && prev_flux >= flux &&
          64'(prev_flux) > bar_now && since_onset >= deaf_ms) begin
        ratio = (64'(prev_flux) * 128) / ((top_flux != 0) ? 64'(top_flux) : 64'd1);
        res.onset    = 1'b1;
        res.strength = (ratio > STRENGTH_MAX) ? STRENGTH_MAX : ratio[STRENGTH_BITS-1:0];
        onset_ring[ring_ptr] = prev_ms;
        if (ring_ptr == PTR_BITS'(RING_DEPTH - 1)) begin
          ring_ptr     = '0;
          ring_wrapped = 1'b1;
        end else begin
          ring_ptr = ring_ptr + 1'b1;
        end
        fired_ms = prev_ms;
      end
      top_flux = top_flux - (top_flux >> PEAK_SHIFT);
      if (prev_flux > top_flux) top_flux = prev_flux;
      prev2_flux = prev_flux;
      prev_flux  = flux;
      // downward step rounds toward minus infinity
      if (flux >= avg_flux)
        avg_flux = avg_flux + ((flux - avg_flux) >> MEAN_SHIFT);
      else
        avg_flux = avg_flux -
                   FLUX_BITS'((25'(avg_flux) - 25'(flux) + 25'(MEAN_ROUND)) >> MEAN_SHIFT);
      res.judged_time_ms = prev_ms;
      res.next_threshold = clip_thr(threshold());
      res.rate_tenths    = onset_rate(now);
      prev_ms = now;
      if (hop_count < 2) hop_count = hop_count + 1'b1;
    end
  endtask

  always @(posedge clk) begin : watch
    out_item_t want;
    if (!rst_n) begin
      clear_state();
      awaited_results.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_idx))
          REG_MEAN_GAIN:     gain      = cfg_wdata[GAIN_BITS-1:0];
          REG_SILENCE_FLOOR: floor_lvl = cfg_wdata[FLOOR_BITS-1:0];
          REG_PEAK_FRACTION: frac      = cfg_wdata[FRAC_BITS-1:0];
          REG_DEAF_TIME:     deaf_ms   = cfg_wdata[DEAF_BITS-1:0];
          default: ;
        endcase
      end
      // the result beat always belongs to an older hop, so check before predicting
      if (out_valid && !out_stall) begin
        if (awaited_results.size() == 0) begin
          bad_results++;
          if (bad_results <= 10)
            $display("%0t: result beat with nothing awaited: %p", $time, out_data);
        end else begin
          want = awaited_results.pop_front();
          if (out_data.onset !== want.onset || out_data.strength !== want.strength ||
              out_data.judged_time_ms !== want.judged_time_ms ||
              out_data.next_threshold !== want.next_threshold ||
              out_data.rate_tenths !== want.rate_tenths) begin
            bad_results++;
            if (bad_results <= 10) begin
              $display("%0t: result mismatch", $time);
              $display("  exp onset %0d str %0d time %0d thr %0d rate %0d",
                       want.onset, want.strength, want.judged_time_ms,
                       want.next_threshold, want.rate_tenths);
              $display("  got onset %0d str %0d time %0d thr %0d rate %0d",
                       out_data.onset, out_data.strength, out_data.judged_time_ms,
                       out_data.next_threshold, out_data.rate_tenths);
            end
          end
        end
      end
      if (in_valid && !in_stall) begin
        judge_hop(in_data, want);
        awaited_results.push_back(want);
      end
    end
    mismatch_count <= bad_results;
    pending_count  <= awaited_results.size();
  end

endmodule

// ===== bench/spectral_flux_onset_picker_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spectral_flux_onset_picker_tb
// Drives hop beats and register settings into the onset picker under
// varying sender gaps and receiver stalls; the checker predicts and compares.
// ----------------------------------------------------------------------------
module spectral_flux_onset_picker_tb;
  import sfop_pkg::*;

  localparam int HOPS_PER_PHASE = 242;
  localparam int HOLD_OFF       = 400;
  localparam int SETTLE         = 40;
  localparam int WATCHDOG       = 5000;

  logic                     clk;
  logic                     rst_n     = 1'b0;
  logic                     in_valid  = 1'b0;
  logic                     in_stall;
  in_item_t                 in_data   = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  out_item_t                out_data;
  logic                     cfg_we    = 1'b0;
  logic [CFG_IDX_BITS-1:0]  cfg_idx   = '0;
  logic [CFG_DATA_BITS-1:0] cfg_wdata = '0;

  int                   mismatch_count;
  int                   pending_count;
  int                   send_idle_pct = 0;
  int                   stall_pct     = 0;
  int                   hold_req      = 0;
  int                   hold_ack      = 0;
  int                   hold_left     = 0;
  int                   quiet_cycles  = 0;
  logic [TIME_BITS-1:0] hop_clock;

  spectral_flux_onset_picker i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  onset_result_checker i_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_data       (out_data),
    .cfg_we         (cfg_we),
    .cfg_idx        (cfg_idx),
    .cfg_wdata      (cfg_wdata),
    .mismatch_count (mismatch_count),
    .pending_count  (pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // receiver: random stalls, or a counted hold-off when one is requested
  always @(negedge clk) begin
    if (hold_ack != hold_req) begin
      hold_ack  = hold_req;
      hold_left = HOLD_OFF;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic in_item_t hop(logic restart, logic [FLUX_BITS-1:0] flux,
                                   logic [TIME_BITS-1:0] t);
    in_item_t h;
    h.restart     = restart;
    h.hop_flux    = flux;
    h.hop_time_ms = t;
    return h;
  endfunction

  // mostly quiet background with isolated spikes of several sizes
  function automatic in_item_t random_hop();
    in_item_t h;
    int       roll;
    h.restart = ($urandom_range(99) < 3);
    roll = $urandom_range(99);
    if (roll < 2)       h.hop_flux = $urandom_range(1) ? '1 : '0;
    else if (roll < 7)  h.hop_flux = FLUX_BITS'($urandom());
    else if (roll < 12) h.hop_flux = FLUX_BITS'($urandom_range(65535));
    else if (roll < 17) h.hop_flux = FLUX_BITS'($urandom_range(4095));
    else                h.hop_flux = FLUX_BITS'($urandom_range(1500));
    roll = $urandom_range(99);
    if (roll < 2)      hop_clock = $urandom();
    else if (roll < 6) hop_clock = hop_clock + $urandom_range(80000, 1000);
    else               hop_clock = hop_clock + $urandom_range(40, 1);
    h.hop_time_ms = hop_clock;
    return h;
  endfunction

  // called and returns at a falling edge
  task automatic send_hop(in_item_t h);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= h;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic wait_results_done();
    in_valid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, int unsigned value);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= CFG_DATA_BITS'(value);
    @(negedge clk);
  endtask

  task automatic load_config(int unsigned gain, int unsigned floor_lvl,
                             int unsigned frac, int unsigned deaf);
    write_reg(REG_MEAN_GAIN, gain);
    write_reg(REG_SILENCE_FLOOR, floor_lvl);
    write_reg(REG_PEAK_FRACTION, frac);
    write_reg(REG_DEAF_TIME, deaf);
    cfg_we <= 1'b0;
  endtask

  task automatic settle();
    wait_results_done();
    repeat (SETTLE) @(negedge clk);
  endtask

  initial begin
    int phase_mode [6] = '{0, 1, 2, 3, 2, 0};
    hop_clock = $urandom();
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    // zero bars: a spike over an empty peak divides by one
    load_config(0, 0, 0, 0);
    send_hop(hop(1'b1, '0, '0));
    send_hop(hop(1'b0, '0, 32'd0));
    send_hop(hop(1'b0, '0, 32'd10));
    send_hop(hop(1'b0, 24'd500, 32'd20));
    send_hop(hop(1'b0, '0, 32'd30));
    // equal neighbors: first of the pair fires, second does not
    send_hop(hop(1'b0, '1, 32'd40));
    send_hop(hop(1'b0, '1, 32'd50));
    send_hop(hop(1'b0, '0, 32'd60));
    send_hop(hop(1'b0, 24'd100, 32'hFFFF_FFF0));
    send_hop(hop(1'b0, 24'd5000, 32'hFFFF_FFFA));
    send_hop(hop(1'b0, '0, 32'd4));
    settle();

    // maximum gain, floor and deaf time; refractory window across the time wrap
    load_config(31, 65535, 16, 65535);
    send_hop(hop(1'b1, '1, '1));
    send_hop(hop(1'b0, '0, 32'hFFFF_FE00));
    send_hop(hop(1'b0, '1, 32'hFFFF_FF00));
    send_hop(hop(1'b0, '0, 32'hFFFF_FF80));
    send_hop(hop(1'b0, '1, 32'h0000_0080));
    send_hop(hop(1'b0, '0, 32'h0000_0100));
    send_hop(hop(1'b0, '1, 32'h0002_0000));
    send_hop(hop(1'b0, '0, 32'h0002_0010));
    settle();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: load_config(13, 800, 10, 130);
        1: load_config(0, 0, 0, 0);
        2: load_config(31, 65535, 16, 0);
        4: load_config(8, 100, 4, 65535);
        default: load_config($urandom_range(31), $urandom_range(65535),
                             $urandom_range(16), $urandom_range(300));
      endcase
      case (phase_mode[ph])
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 79; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 79; end
        default: begin send_idle_pct = 22; stall_pct = 22; end
      endcase
      for (int n = 0; n < HOPS_PER_PHASE; n++) begin
        if (ph == 3 && n == HOPS_PER_PHASE / 2) wait_results_done();
        // long receiver hold-off while hops keep coming
        if (ph == 5 && n == 60) hold_req++;
        send_hop(random_hop());
      end
      settle();
    end

    if (mismatch_count == 0 && pending_count == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

// ===== files.f =====
hdl/sfop_pkg.sv
hdl/sfop_cmpsub.sv
hdl/sfop_ring.sv
hdl/spectral_flux_onset_picker.sv
bench/onset_result_checker.sv
bench/spectral_flux_onset_picker_tb.sv
